### design/hcbst_pkg.sv
// Shared types and codes for the hot-cue beat snap table.
package hcbst_pkg;

  typedef enum logic [3:0] {
    CMD_NEW_TRACK = 4'd0,
    CMD_APPEND    = 4'd1,
    CMD_SET_POS   = 4'd2,
    CMD_SET_NEXT  = 4'd3,
    CMD_CLEAR     = 4'd4,
    CMD_JUMP      = 4'd5,
    CMD_TRIGGER   = 4'd6,
    CMD_ARM       = 4'd7,
    CMD_DISARM    = 4'd8,
    CMD_JUMP_NEW  = 4'd9
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SEEK     = 3'd0,
    KIND_STORED   = 3'd1,
    KIND_CLEARED  = 3'd2,
    KIND_RANGE    = 3'd3,
    KIND_DECK_CLR = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_NEW_TRACK,
    OP_APPEND,
    OP_SET_POS,
    OP_SET_NEXT,
    OP_ARM,
    OP_DISARM,
    OP_CLEAR_ARG,
    OP_SEL_ARG,
    OP_SEL_NEXT,
    OP_CLEAR_SEL,
    OP_MARK,
    OP_JUMP_CLEAR,
    OP_CB_READ,
    OP_IDX_ERR,
    OP_BEAT_READ,
    OP_SEEK,
    OP_RD_FIRST,
    OP_RD_LAST,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_SNAP,
    OP_STORE
  } dp_op_e;

  typedef enum logic [1:0] {
    SNAP_NONE,
    SNAP_FIRST,
    SNAP_LAST,
    SNAP_PICK
  } snap_e;

  typedef struct packed {
    dp_op_e op;
    snap_e  snap;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic deck_ok;
    logic slot_ok;
    logic armed;
    logic cue_valid;
    logic few_beats;
    logic pos_le_rd;
    logic pos_ge_rd;
    logic in_interval;
    logic scan_last;
    logic idx_bad;
    logic out_free;
  } dp_status_t;

  function automatic logic is_result_op(dp_op_e op);
    return (op == OP_NEW_TRACK) || (op == OP_CLEAR_ARG) || (op == OP_CLEAR_SEL) ||
           (op == OP_JUMP_CLEAR) || (op == OP_IDX_ERR) || (op == OP_SEEK) ||
           (op == OP_STORE);
  endfunction

endpackage

### design/hcbst_ctrl.sv
// Command sequencer for the hot-cue table: decode, cue jump and beat scan.
module hcbst_ctrl import hcbst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t stat_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_JNEW  = 4'd2;
  localparam logic [3:0] S_JUMP  = 4'd3;
  localparam logic [3:0] S_JDEC  = 4'd4;
  localparam logic [3:0] S_CBCHK = 4'd5;
  localparam logic [3:0] S_SEEK  = 4'd6;
  localparam logic [3:0] S_SB0   = 4'd7;
  localparam logic [3:0] S_SBN   = 4'd8;
  localparam logic [3:0] S_SCAN  = 4'd9;
  localparam logic [3:0] S_STORE = 4'd10;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.snap  = SNAP_NONE;
    in_stall_o  = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        state_d = S_IDLE;
        if (stat_i.deck_ok) begin
          unique case (stat_i.cmd)
            CMD_NEW_TRACK: begin
              if (stat_i.out_free) cmd_o.op = OP_NEW_TRACK;
              else state_d = S_DEC;
            end
            CMD_APPEND:  cmd_o.op = OP_APPEND;
            CMD_SET_POS: cmd_o.op = OP_SET_POS;
            CMD_SET_NEXT: begin
              if (stat_i.slot_ok) cmd_o.op = OP_SET_NEXT;
            end
            CMD_CLEAR: begin
              if (stat_i.slot_ok) begin
                if (stat_i.out_free) cmd_o.op = OP_CLEAR_ARG;
                else state_d = S_DEC;
              end
            end
            CMD_JUMP: begin
              if (stat_i.slot_ok) begin
                cmd_o.op = OP_SEL_ARG;
                state_d  = S_JUMP;
              end
            end
            CMD_TRIGGER: begin
              cmd_o.op = OP_SEL_NEXT;
              state_d  = S_JUMP;
            end
            CMD_ARM:    cmd_o.op = OP_ARM;
            CMD_DISARM: cmd_o.op = OP_DISARM;
            CMD_JUMP_NEW: begin
              cmd_o.op = OP_SEL_NEXT;
              state_d  = S_JNEW;
            end
            default: ;
          endcase
        end
      end
      S_JNEW: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_CLEAR_SEL;
          state_d  = S_JUMP;
        end
      end
      S_JUMP: begin
        cmd_o.op = OP_MARK;
        state_d  = S_JDEC;
      end
      S_JDEC: begin
        if (stat_i.armed) begin
          if (stat_i.out_free) begin
            cmd_o.op = OP_JUMP_CLEAR;
            state_d  = S_IDLE;
          end
        end else if (stat_i.cue_valid) begin
          cmd_o.op = OP_CB_READ;
          state_d  = S_CBCHK;
        end else if (stat_i.few_beats) begin
          cmd_o.op   = OP_SNAP;
          cmd_o.snap = SNAP_NONE;
          state_d    = S_STORE;
        end else begin
          cmd_o.op = OP_RD_FIRST;
          state_d  = S_SB0;
        end
      end
      S_CBCHK: begin
        if (stat_i.idx_bad) begin
          if (stat_i.out_free) begin
            cmd_o.op = OP_IDX_ERR;
            state_d  = S_IDLE;
          end
        end else begin
          cmd_o.op = OP_BEAT_READ;
          state_d  = S_SEEK;
        end
      end
      S_SEEK: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_SEEK;
          state_d  = S_IDLE;
        end
      end
      S_SB0: begin
        if (stat_i.pos_le_rd) begin
          cmd_o.op   = OP_SNAP;
          cmd_o.snap = SNAP_FIRST;
          state_d    = S_STORE;
        end else begin
          cmd_o.op = OP_RD_LAST;
          state_d  = S_SBN;
        end
      end
      S_SBN: begin
        if (stat_i.pos_ge_rd) begin
          cmd_o.op   = OP_SNAP;
          cmd_o.snap = SNAP_LAST;
          state_d    = S_STORE;
        end else begin
          cmd_o.op = OP_SCAN_START;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.in_interval) begin
          cmd_o.op   = OP_SNAP;
          cmd_o.snap = SNAP_PICK;
          state_d    = S_STORE;
        end else if (stat_i.scan_last) begin
          cmd_o.op   = OP_SNAP;
          cmd_o.snap = SNAP_NONE;
          state_d    = S_STORE;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
        end
      end
      S_STORE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_STORE;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### design/hcbst_dp.sv
// Datapath: per-deck state, cue flags, beat and cue memories, output register.
module hcbst_dp import hcbst_pkg::*; #(
  parameter int DECKS     = 2,
  parameter int MAX_BEATS = 4096,
  parameter int CUE_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         stat_o,
  input  logic [3:0]         command_i,
  input  logic               deck_i,
  input  logic [30:0]        argument_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic               out_deck_o,
  output logic [5:0]         cue_number_o,
  output logic [30:0]        seek_frame_o,
  output logic signed [12:0] beat_index_o,
  output logic               last_o
);

  localparam int DW = (DECKS > 1) ? $clog2(DECKS) : 1;
  localparam int BW = $clog2(MAX_BEATS);
  localparam int NW = $clog2(MAX_BEATS + 1);
  localparam int CW = (CUE_SLOTS > 1) ? $clog2(CUE_SLOTS) : 1;
  localparam int IW = BW + 1;

  // item
  logic [3:0]  cmd_q;
  logic        deck_q;
  logic [30:0] arg_q;

  // per-deck state
  logic [NW-1:0]        count_q [DECKS];
  logic [30:0]          pos_q   [DECKS];
  logic [CW-1:0]        next_q  [DECKS];
  logic                 armed_q [DECKS];
  logic [CUE_SLOTS-1:0] valid_q [DECKS];

  // work registers
  logic [CW-1:0]        cue_q;
  logic [30:0]          lo_q;
  logic [BW-1:0]        i_q;
  logic signed [IW-1:0] snap_q, snap_d;
  logic [30:0]          rd_q;
  logic signed [IW-1:0] cb_q;

  logic [30:0]          beat_mem [DECKS][MAX_BEATS];
  logic signed [IW-1:0] cb_mem   [DECKS][CUE_SLOTS];

  // output register
  logic                 out_valid_q;
  kind_e                kind_q, kind_d;
  logic                 odeck_q;
  logic [5:0]           cue6_q, cue6_d;
  logic [30:0]          seek_q, seek_d;
  logic signed [12:0]   beat_q, beat_d;
  logic                 last_q, last_d;

  logic [DW-1:0] dk;
  logic [CW-1:0] arg_cue;
  logic [NW-1:0] count_cur;
  logic [NW-1:0] last_idx;
  logic [30:0]   pos_cur;
  logic          full;
  logic          res_op;
  logic          pick_lo;
  logic          br_en;
  logic [BW-1:0] br_addr;

  assign dk        = DW'(deck_q);
  assign arg_cue   = arg_q[CW-1:0];
  assign count_cur = count_q[dk];
  assign last_idx  = count_cur - NW'(1);
  assign pos_cur   = pos_q[dk];
  assign full      = (count_cur >= NW'(MAX_BEATS));
  assign res_op    = is_result_op(cmd_i.op);
  // f - lo < hi - f  <=>  2f < lo + hi
  assign pick_lo   = ({pos_cur, 1'b0} < ({1'b0, lo_q} + {1'b0, rd_q}));

  always_comb begin
    stat_o.cmd         = cmd_e'(cmd_q);
    stat_o.deck_ok     = ((DW + 1)'(deck_q) < (DW + 1)'(DECKS));
    stat_o.slot_ok     = (arg_q < 31'(CUE_SLOTS));
    stat_o.armed       = armed_q[dk];
    stat_o.cue_valid   = valid_q[dk][cue_q];
    stat_o.few_beats   = (count_cur <= NW'(2));
    stat_o.pos_le_rd   = (pos_cur <= rd_q);
    stat_o.pos_ge_rd   = (pos_cur >= rd_q);
    stat_o.in_interval = (pos_cur >= lo_q) && (pos_cur < rd_q);
    stat_o.scan_last   = (NW'(i_q) == last_idx);
    stat_o.idx_bad     = cb_q[IW-1] || (NW'(cb_q[IW-2:0]) >= count_cur);
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    br_en   = 1'b1;
    br_addr = '0;
    case (cmd_i.op)
      OP_RD_FIRST:   br_addr = '0;
      OP_RD_LAST:    br_addr = BW'(last_idx);
      OP_SCAN_START: br_addr = BW'(1);
      OP_SCAN_NEXT:  br_addr = i_q + BW'(1);
      OP_BEAT_READ:  br_addr = cb_q[BW-1:0];
      default:       br_en = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd_i.snap)
      SNAP_NONE:  snap_d = '1;
      SNAP_FIRST: snap_d = '0;
      SNAP_LAST:  snap_d = IW'(last_idx);
      SNAP_PICK:  snap_d = {1'b0, (pick_lo ? (i_q - BW'(1)) : i_q)};
      default:    snap_d = '1;
    endcase
  end

  always_comb begin
    kind_d = KIND_SEEK;
    cue6_d = '0;
    seek_d = '0;
    beat_d = '0;
    last_d = 1'b1;
    case (cmd_i.op)
      OP_NEW_TRACK: kind_d = KIND_DECK_CLR;
      OP_CLEAR_ARG: begin
        kind_d = KIND_CLEARED;
        cue6_d = 6'(arg_cue);
      end
      OP_CLEAR_SEL: begin
        kind_d = KIND_CLEARED;
        cue6_d = 6'(cue_q);
        last_d = 1'b0;
      end
      OP_JUMP_CLEAR: begin
        kind_d = KIND_CLEARED;
        cue6_d = 6'(cue_q);
      end
      OP_IDX_ERR: begin
        kind_d = KIND_RANGE;
        cue6_d = 6'(cue_q);
        beat_d = 13'(cb_q);
      end
      OP_SEEK: seek_d = rd_q;
      OP_STORE: begin
        kind_d = KIND_STORED;
        cue6_d = 6'(cue_q);
        beat_d = 13'(snap_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DECKS; k++) begin
        count_q[k] <= '0;
        pos_q[k]   <= '0;
        next_q[k]  <= '0;
        armed_q[k] <= 1'b0;
        valid_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_NEW_TRACK: begin
          count_q[dk] <= '0;
          pos_q[dk]   <= '0;
          next_q[dk]  <= '0;
          armed_q[dk] <= 1'b0;
          valid_q[dk] <= '0;
        end
        OP_APPEND: begin
          if (!full) count_q[dk] <= count_cur + NW'(1);
        end
        OP_SET_POS:  pos_q[dk] <= arg_q;
        OP_SET_NEXT: next_q[dk] <= arg_cue;
        OP_ARM:      armed_q[dk] <= 1'b1;
        OP_DISARM:   armed_q[dk] <= 1'b0;
        OP_CLEAR_ARG: begin
          valid_q[dk][arg_cue] <= 1'b0;
          armed_q[dk]          <= 1'b0;
        end
        OP_CLEAR_SEL: valid_q[dk][cue_q] <= 1'b0;
        OP_MARK:      next_q[dk] <= cue_q;
        OP_JUMP_CLEAR: begin
          valid_q[dk][cue_q] <= 1'b0;
          armed_q[dk]        <= 1'b0;
        end
        OP_STORE: valid_q[dk][cue_q] <= 1'b1;
        default: ;
      endcase
      if (res_op) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      cmd_q  <= command_i;
      deck_q <= deck_i;
      arg_q  <= argument_i;
    end
    if (cmd_i.op == OP_SEL_ARG) cue_q <= arg_cue;
    if (cmd_i.op == OP_SEL_NEXT) cue_q <= next_q[dk];
    if (cmd_i.op == OP_RD_LAST || cmd_i.op == OP_SCAN_NEXT) lo_q <= rd_q;
    if (cmd_i.op == OP_SCAN_START) i_q <= BW'(1);
    if (cmd_i.op == OP_SCAN_NEXT) i_q <= i_q + BW'(1);
    if (cmd_i.op == OP_SNAP) snap_q <= snap_d;
    if (res_op) begin
      kind_q  <= kind_d;
      odeck_q <= deck_q;
      cue6_q  <= cue6_d;
      seek_q  <= seek_d;
      beat_q  <= beat_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_APPEND && !full) beat_mem[dk][count_cur[BW-1:0]] <= arg_q;
    if (br_en) rd_q <= beat_mem[dk][br_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_STORE) cb_mem[dk][cue_q] <= snap_q;
    if (cmd_i.op == OP_CB_READ) cb_q <= cb_mem[dk][cue_q];
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign out_deck_o   = odeck_q;
  assign cue_number_o = cue6_q;
  assign seek_frame_o = seek_q;
  assign beat_index_o = beat_q;
  assign last_o       = last_q;

endmodule

### design/hot_cue_beat_snap_table_core.sv
// Top level of the per-deck hot-cue table with nearest-beat snapping.
// Input channel: in_valid_i/in_stall_o carries command_i, deck_i, argument_i.
// An item is taken when in_valid_i is high and in_stall_o is low; the block
// then raises in_stall_o until the item is finished, one item at a time.
// Output channel: out_valid_o/out_stall_i carries kind_o, out_deck_o,
// cue_number_o, seek_frame_o, beat_index_o and last_o from an output
// register; an item gives zero, one or two results, last_o marks the final.
// A jump to an empty cue scans the deck's beat grid through the single
// read port of the beat memory, one beat per cycle.
// A stalled receiver holds the result; the block finishes and waits with
// the next result until the output register is free, and takes a new item
// as soon as its last result sits in that register.
// Reset clears beat counts, positions, next cues, arm flags and all cue
// flags at once; the beat and cue memories need no clearing pass.
module hot_cue_beat_snap_table_core import hcbst_pkg::*; #(
  parameter int DECKS     = 2,
  parameter int MAX_BEATS = 4096,
  parameter int CUE_SLOTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         command_i,
  input  logic               deck_i,
  input  logic [30:0]        argument_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic               out_deck_o,
  output logic [5:0]         cue_number_o,
  output logic [30:0]        seek_frame_o,
  output logic signed [12:0] beat_index_o,
  output logic               last_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_stat;

  hcbst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  hcbst_dp #(
    .DECKS     (DECKS),
    .MAX_BEATS (MAX_BEATS),
    .CUE_SLOTS (CUE_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .command_i    (command_i),
    .deck_i       (deck_i),
    .argument_i   (argument_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .out_deck_o   (out_deck_o),
    .cue_number_o (cue_number_o),
    .seek_frame_o (seek_frame_o),
    .beat_index_o (beat_index_o),
    .last_o       (last_o)
  );

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_result_op(dp_cmd.op) |-> dp_stat.out_free)
    else $error("result issued while output register occupied");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after item accepted");

  a_valid_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(is_result_op(dp_cmd.op)))
    else $error("output valid without a result operation");

endmodule

### dv/tb_hot_cue_beat_snap_table_core.sv
// Self-checking testbench for the hot-cue beat snap table core.
module tb_hot_cue_beat_snap_table_core import hcbst_pkg::*; ();

  localparam int DECKS          = 2;
  localparam int MAX_BEATS      = 4096;
  localparam int CUE_SLOTS      = 64;
  localparam int SNAP_MIN_BEATS = 2;
  localparam int RAND_ITEMS     = 100;
  localparam int DRAIN_CYCLES   = 64;
  localparam int CYCLE_LIMIT    = 600000;
  localparam logic [3:0] CMD_BAD_FIRST = 4'd10;
  localparam logic [3:0] CMD_BAD_LAST  = 4'd15;
  localparam logic [30:0] ARG_MAX = 31'h7FFF_FFFF;

  typedef struct {
    logic [3:0]  cmd;
    logic        dk;
    logic [30:0] arg;
    int          gap;
  } deck_cmd_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic               dk;
    logic [5:0]         cue;
    logic [30:0]        seek;
    logic signed [12:0] beat;
    logic               last;
  } cue_res_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [3:0] command_i = '0;
  logic deck_i = 1'b0;
  logic [30:0] argument_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [2:0] kind_o;
  logic out_deck_o;
  logic [5:0] cue_number_o;
  logic [30:0] seek_frame_o;
  logic signed [12:0] beat_index_o;
  logic last_o;

  // predicted deck state
  bit [30:0] grid [DECKS][MAX_BEATS];
  int        grid_len [DECKS];
  bit        slot_set [DECKS][CUE_SLOTS];
  int        slot_beat [DECKS][CUE_SLOTS];
  bit [30:0] play_pos [DECKS];
  int        next_slot [DECKS];
  bit        arm_flag [DECKS];

  deck_cmd_t cmd_q[$];
  cue_res_t  cue_results_q[$];
  deck_cmd_t cur_cmd;
  int items_total = 0;
  int items_taken = 0;
  int idle_cnt = 0;
  int stall_left = 0;
  int res_cnt = 0;
  int err_cnt = 0;
  int cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  hot_cue_beat_snap_table_core #(
    .DECKS    (DECKS),
    .MAX_BEATS(MAX_BEATS),
    .CUE_SLOTS(CUE_SLOTS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .deck_i      (deck_i),
    .argument_i  (argument_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .out_deck_o  (out_deck_o),
    .cue_number_o(cue_number_o),
    .seek_frame_o(seek_frame_o),
    .beat_index_o(beat_index_o),
    .last_o      (last_o)
  );

  function automatic void post(logic [2:0] k, int d, int c, logic [30:0] s, int b);
    cue_res_t r;
    r = '{k, d[0], c[5:0], s, b[12:0], 1'b0};
    cue_results_q = {cue_results_q, r};
  endfunction

  function automatic int snap_index(int d);
    int n;
    bit [30:0] f, lo, hi;
    n = grid_len[d];
    f = play_pos[d];
    if (n <= SNAP_MIN_BEATS) return -1;
    if (f <= grid[d][0]) return 0;
    if (f >= grid[d][n-1]) return n - 1;
    for (int i = 1; i < n; i++) begin
      lo = grid[d][i-1];
      hi = grid[d][i];
      if (f >= lo && f < hi) return (f - lo < hi - f) ? i - 1 : i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int d, int c);
    slot_set[d][c] = 1'b0;
    post(KIND_CLEARED, d, c, '0, 0);
  endfunction

  function automatic void jump_slot(int d, int c);
    int b;
    next_slot[d] = c;
    if (arm_flag[d]) begin
      arm_flag[d] = 1'b0;
      drop_slot(d, c);
    end else if (slot_set[d][c]) begin
      b = slot_beat[d][c];
      if (b < 0 || b >= grid_len[d]) post(KIND_RANGE, d, c, '0, b);
      else post(KIND_SEEK, d, 0, grid[d][b], 0);
    end else begin
      b = snap_index(d);
      slot_set[d][c] = 1'b1;
      slot_beat[d][c] = b;
      post(KIND_STORED, d, c, '0, b);
    end
  endfunction

  function automatic void apply_deck_cmd(deck_cmd_t it);
    int d, res_base, c;
    d = it.dk;
    res_base = cue_results_q.size();
    if (d >= DECKS) return;
    case (it.cmd)
      CMD_NEW_TRACK: begin
        grid_len[d] = 0;
        for (int k = 0; k < CUE_SLOTS; k++) slot_set[d][k] = 1'b0;
        play_pos[d] = '0;
        next_slot[d] = 0;
        arm_flag[d] = 1'b0;
        post(KIND_DECK_CLR, d, 0, '0, 0);
      end
      CMD_APPEND: begin
        if (grid_len[d] < MAX_BEATS) begin
          grid[d][grid_len[d]] = it.arg;
          grid_len[d]++;
        end
      end
      CMD_SET_POS: play_pos[d] = it.arg;
      CMD_SET_NEXT: if (it.arg < CUE_SLOTS) next_slot[d] = it.arg;
      CMD_CLEAR: begin
        if (it.arg < CUE_SLOTS) begin
          drop_slot(d, it.arg);
          arm_flag[d] = 1'b0;
        end
      end
      CMD_JUMP: if (it.arg < CUE_SLOTS) jump_slot(d, it.arg);
      CMD_TRIGGER: jump_slot(d, next_slot[d] % CUE_SLOTS);
      CMD_ARM: arm_flag[d] = 1'b1;
      CMD_DISARM: arm_flag[d] = 1'b0;
      CMD_JUMP_NEW: begin
        c = next_slot[d] % CUE_SLOTS;
        drop_slot(d, c);
        jump_slot(d, c);
      end
      default: ;
    endcase
    if (cue_results_q.size() > res_base)
      cue_results_q[cue_results_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [30:0] rand31();
    logic [31:0] r;
    r = $urandom();
    return r[30:0];
  endfunction

  function automatic logic [30:0] cue_arg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 31'($urandom_range(0, 7));
    if (r < 90) return 31'($urandom_range(0, CUE_SLOTS - 1));
    if (r < 95) return 31'(CUE_SLOTS);
    return rand31() | 31'h4000_0000;
  endfunction

  function automatic void put_cmd(logic [3:0] c, logic d, logic [30:0] a);
    deck_cmd_t it;
    it.cmd = c;
    it.dk = d;
    it.arg = a;
    it.gap = ((cmd_q.size() / 24) % 3 == 0) ? 0 : $urandom_range(0, 9);
    cmd_q = {cmd_q, it};
  endfunction

  function automatic void log_mismatch(string tag, cue_res_t want, cue_res_t seen);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s: exp kind=%0d deck=%0d cue=%0d seek=%0d beat=%0d last=%0d",
               tag, want.kind, want.dk, want.cue, want.seek, want.beat, want.last);
      $display("%s: got kind=%0d deck=%0d cue=%0d seek=%0d beat=%0d last=%0d",
               tag, seen.kind, seen.dk, seen.cue, seen.seek, seen.beat, seen.last);
    end
  endfunction

  // driver
  always @(posedge clk or negedge rst_ni) begin
    logic busy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i <= '0;
      deck_i <= 1'b0;
      argument_i <= '0;
      idle_cnt <= 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        apply_deck_cmd(cur_cmd);
        items_taken++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (cmd_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_cnt < cmd_q[0].gap) begin
          idle_cnt <= idle_cnt + 1;
          in_valid_i <= 1'b0;
        end else begin
          cur_cmd = cmd_q.pop_front();
          command_i <= cur_cmd.cmd;
          deck_i <= cur_cmd.dk;
          argument_i <= cur_cmd.arg;
          in_valid_i <= 1'b1;
          idle_cnt <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_ni) begin
    cue_res_t seen, want;
    int hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      hold = stall_left;
      if (out_valid_o && !out_stall_i) begin
        seen = '{kind_o, out_deck_o, cue_number_o, seek_frame_o, beat_index_o, last_o};
        res_cnt++;
        if (cue_results_q.size() == 0) begin
          log_mismatch("unexpected", '0, seen);
        end else begin
          want = cue_results_q.pop_front();
          if (seen !== want) log_mismatch("mismatch", want, seen);
        end
        hold = ((res_cnt / 16) % 3 == 0) ? 0 : $urandom_range(0, 9);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        stall_left <= hold - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int r, n, d, goal;
    logic [30:0] base;

    // directed
    put_cmd(CMD_NEW_TRACK, 1'b0, '0);
    put_cmd(CMD_JUMP, 1'b0, 31'd0);          // too few beats: index none
    put_cmd(CMD_JUMP, 1'b0, 31'd0);          // stored none: out of range
    put_cmd(CMD_APPEND, 1'b0, 31'd100);
    put_cmd(CMD_APPEND, 1'b0, 31'd200);
    put_cmd(CMD_APPEND, 1'b0, 31'd300);
    put_cmd(CMD_SET_POS, 1'b0, 31'd250);
    put_cmd(CMD_JUMP, 1'b0, 31'd1);          // tie goes to later beat
    put_cmd(CMD_JUMP, 1'b0, 31'd1);
    put_cmd(CMD_SET_POS, 1'b0, 31'd0);
    put_cmd(CMD_JUMP, 1'b0, 31'd2);
    put_cmd(CMD_SET_POS, 1'b0, ARG_MAX);
    put_cmd(CMD_JUMP, 1'b0, 31'(CUE_SLOTS - 1));
    put_cmd(CMD_ARM, 1'b0, '0);
    put_cmd(CMD_JUMP, 1'b0, 31'd1);          // armed jump clears
    put_cmd(CMD_ARM, 1'b0, ARG_MAX);
    put_cmd(CMD_DISARM, 1'b0, '0);
    put_cmd(CMD_TRIGGER, 1'b0, '0);
    put_cmd(CMD_SET_NEXT, 1'b0, 31'd5);
    put_cmd(CMD_JUMP_NEW, 1'b0, '0);
    put_cmd(CMD_ARM, 1'b0, '0);
    put_cmd(CMD_JUMP_NEW, 1'b0, '0);
    put_cmd(CMD_CLEAR, 1'b0, 31'(CUE_SLOTS - 1));
    put_cmd(CMD_CLEAR, 1'b0, 31'(CUE_SLOTS));
    put_cmd(CMD_JUMP, 1'b0, ARG_MAX);
    put_cmd(CMD_SET_NEXT, 1'b0, 31'(CUE_SLOTS));
    put_cmd(CMD_BAD_LAST, 1'b1, ARG_MAX);
    put_cmd(CMD_BAD_FIRST, 1'b0, '0);
    put_cmd(CMD_APPEND, 1'b1, 31'd500);      // unordered grid
    put_cmd(CMD_APPEND, 1'b1, 31'd100);
    put_cmd(CMD_APPEND, 1'b1, 31'd900);
    put_cmd(CMD_SET_POS, 1'b1, 31'd700);
    put_cmd(CMD_ARM, 1'b1, '0);
    put_cmd(CMD_CLEAR, 1'b1, 31'd0);         // clear disarms
    put_cmd(CMD_JUMP, 1'b1, 31'd0);

    // random
    goal = cmd_q.size() + RAND_ITEMS;
    while (cmd_q.size() < goal) begin
      r = $urandom_range(0, 99);
      d = $urandom_range(0, DECKS - 1);
      if (r < 10) begin
        put_cmd(CMD_NEW_TRACK, d[0], rand31());
        n = $urandom_range(3, 12);
        base = 31'($urandom_range(0, 1000000));
        repeat (n) begin
          base = base + 31'($urandom_range(1, 20000));
          put_cmd(CMD_APPEND, d[0], base);
        end
      end else if (r < 18) put_cmd(CMD_APPEND, d[0], ($urandom_range(0, 3) == 0) ? rand31() :
                                   31'($urandom_range(0, 1300000)));
      else if (r < 30) put_cmd(CMD_SET_POS, d[0], ($urandom_range(0, 4) == 0) ? rand31() :
                                 31'($urandom_range(0, 1300000)));
      else if (r < 36) put_cmd(CMD_SET_NEXT, d[0], cue_arg());
      else if (r < 42) put_cmd(CMD_CLEAR, d[0], cue_arg());
      else if (r < 62) put_cmd(CMD_JUMP, d[0], cue_arg());
      else if (r < 72) put_cmd(CMD_TRIGGER, d[0], rand31());
      else if (r < 79) put_cmd(CMD_ARM, d[0], rand31());
      else if (r < 83) put_cmd(CMD_DISARM, d[0], rand31());
      else if (r < 96) put_cmd(CMD_JUMP_NEW, d[0], rand31());
      else put_cmd(4'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST)), d[0], rand31());
    end
    items_total = cmd_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    while (items_taken < items_total || cue_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0 && cue_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
